// ===== hdl/frsm_pkg.sv =====
// Shared types and constants for the fan ripple stall monitor.
`timescale 1ns / 1ps
`default_nettype none

package frsm_pkg;

    localparam int LEVEL_BITS  = 12;
    localparam int STALL_BITS  = 4;
    localparam int TICK_BITS   = 4;
    localparam int RUN_BITS    = 16;
    localparam int RIPPLE_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIPPLE_LIMIT_ONE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIPPLE_LIMIT_TWO = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUNNING_COUNT    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUPPLY_ON_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPORT_TICKS     = 3'd5;

    // Register reset values
    localparam logic [LEVEL_BITS-1:0] RST_RIPPLE_LIMIT_ONE = 12'd700;
    localparam logic [LEVEL_BITS-1:0] RST_RIPPLE_LIMIT_TWO = 12'd800;
    localparam logic [STALL_BITS-1:0] RST_STALL_LIMIT      = 4'd10;
    localparam logic [RUN_BITS-1:0]   RST_RUNNING_COUNT    = 16'd100;
    localparam logic [LEVEL_BITS-1:0] RST_SUPPLY_ON_LEVEL  = 12'd253;
    localparam logic [TICK_BITS-1:0]  RST_REPORT_TICKS     = 4'd5;

    localparam logic [STALL_BITS-1:0] STALL_MAX = 4'd15;

    // Request command codes
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    // Reported fan status
    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_ERROR     = 2'd1,
        ST_POWER_OFF = 2'd2,
        ST_RUNNING   = 2'd3
    } t_fan_status;

endpackage

`default_nettype wire

// ===== hdl/frsm_req_if.sv =====
// Request channel: ADC sample sets and timer ticks.
`timescale 1ns / 1ps
`default_nettype none

interface frsm_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [frsm_pkg::LEVEL_BITS-1:0]  fan_one_level;
    logic [frsm_pkg::LEVEL_BITS-1:0]  fan_two_level;
    logic [frsm_pkg::LEVEL_BITS-1:0]  supply_level;

    modport source (
        output valid, cmd, fan_one_level, fan_two_level, supply_level,
        input  ready
    );
    modport sink (
        input  valid, cmd, fan_one_level, fan_two_level, supply_level,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/frsm_rsp_if.sv =====
// Result channel: fan status and ripple counts.
`timescale 1ns / 1ps
`default_nettype none

interface frsm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        fan_one_status;
    logic [1:0]                        fan_two_status;
    logic                              report_done;
    logic [frsm_pkg::RIPPLE_BITS-1:0]  fan_one_ripples;
    logic [frsm_pkg::RIPPLE_BITS-1:0]  fan_two_ripples;

    modport source (
        output valid, fan_one_status, fan_two_status, report_done,
               fan_one_ripples, fan_two_ripples,
        input  ready
    );
    modport sink (
        input  valid, fan_one_status, fan_two_status, report_done,
               fan_one_ripples, fan_two_ripples,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/fan_ripple_stall_monitor.sv =====
// Top level of the two-fan ripple stall monitor.
//
// Usage:
//   i_req carries one request per handshake: cmd 0 is an ADC sample set
//   (both fan ripple levels plus the fan supply level), cmd 1 is a timer tick.
//   Every request yields exactly one result on o_rsp: the latest status of
//   each fan, a report_done flag and both ripple counts after the request.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data; the user keeps this to times when no request is in flight,
//   which the block itself does not enforce. Unknown indexes are dropped.
// Timing:
//   State and result register update at the edge that accepts the request.
//   Throughput is one request per cycle while o_rsp.ready is high, set by the
//   single result register feeding o_rsp.
//
// Reset (synchronous, active low) loads the register defaults, clears all
//   fan state, tick counter and statuses, and empties the result register.
// Stall: while the result waits, i_req.ready stays high only if o_rsp.ready
//   is high, so a held result is never overwritten and no request is lost.
`timescale 1ns / 1ps
`default_nettype none

module fan_ripple_stall_monitor #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    frsm_req_if.sink                                  i_req,
    frsm_rsp_if.source                                o_rsp,
    input  wire logic                                 i_cfg_we,
    input  wire logic [frsm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [frsm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int LB = frsm_pkg::LEVEL_BITS;
    localparam int SB = frsm_pkg::STALL_BITS;
    localparam int TB = frsm_pkg::TICK_BITS;
    localparam int RB = frsm_pkg::RUN_BITS;
    localparam int OB = frsm_pkg::RIPPLE_BITS;
    // compare / output width covering both the counter and the 16-bit fields
    localparam int CW = (COUNT_BITS > RB) ? ((COUNT_BITS > OB) ? COUNT_BITS : OB)
                                          : ((RB > OB) ? RB : OB);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [LB-1:0] r_limit_one, r_limit_two, r_supply_on_level;
    logic [SB-1:0] r_stall_limit;
    logic [RB-1:0] r_running_count;
    logic [TB-1:0] r_report_ticks;

    // fan state
    logic [LB-1:0]         r_last_one, r_last_two;
    logic [COUNT_BITS-1:0] r_ripples_one, r_ripples_two;
    logic [SB-1:0]         r_stall_one, r_stall_two;
    logic [TB-1:0]         r_tick;
    logic                  r_supply_on;
    frsm_pkg::t_fan_status r_status_one, r_status_two;

    logic [COUNT_BITS-1:0] n_ripples_one, n_ripples_two;
    logic [SB-1:0]         n_stall_one, n_stall_two;
    logic [TB-1:0]         n_tick;
    frsm_pkg::t_fan_status n_status_one, n_status_two;
    logic                  n_done;

    // ripple counts widened to cover the output fields
    logic [CW-1:0]         ripples_one_ext, ripples_two_ext;

    // result register
    logic                  r_out_valid;
    logic [1:0]            r_out_status_one, r_out_status_two;
    logic                  r_out_done;
    logic [OB-1:0]         r_out_ripples_one, r_out_ripples_two;

    logic accept;
    logic is_tick;

    // per-fan update results
    typedef struct packed {
        logic [COUNT_BITS-1:0] ripples;
        logic [SB-1:0]         stall;
    } t_fan_next;

    t_fan_next fan_one_nx, fan_two_nx;

    function automatic t_fan_next watch_fan(
        input logic [LB-1:0]         level,
        input logic [LB-1:0]         limit,
        input logic [LB-1:0]         last,
        input logic [COUNT_BITS-1:0] ripples,
        input logic [SB-1:0]         stall,
        input logic [SB-1:0]         stall_limit
    );
        logic [LB-1:0] diff;
        t_fan_next     nx;
        diff = (level > last) ? (level - last) : (last - level);
        nx.ripples = ripples;
        nx.stall   = stall;
        if ((level < limit) && (diff > LB'(1))) begin
            if (ripples != COUNT_MAX) begin
                nx.ripples = ripples + COUNT_BITS'(1);
            end
            nx.stall = '0;
        end else if (stall != frsm_pkg::STALL_MAX) begin
            nx.stall = stall + SB'(1);
        end
        if (nx.stall == stall_limit) begin
            nx.ripples = '0;
        end
        return nx;
    endfunction

    function automatic frsm_pkg::t_fan_status classify(
        input logic [COUNT_BITS-1:0] ripples,
        input logic [RB-1:0]         running,
        input logic                  supply_on
    );
        frsm_pkg::t_fan_status st;
        if (CW'(ripples) > CW'(running)) begin
            st = frsm_pkg::ST_RUNNING;
        end else if (supply_on) begin
            st = frsm_pkg::ST_ERROR;
        end else begin
            st = frsm_pkg::ST_POWER_OFF;
        end
        return st;
    endfunction

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_tick     = (frsm_pkg::t_cmd'(i_req.cmd) == frsm_pkg::CMD_TICK);

    always_comb begin
        fan_one_nx = watch_fan(i_req.fan_one_level, r_limit_one, r_last_one,
                               r_ripples_one, r_stall_one, r_stall_limit);
        fan_two_nx = watch_fan(i_req.fan_two_level, r_limit_two, r_last_two,
                               r_ripples_two, r_stall_two, r_stall_limit);
    end

    always_comb begin
        n_ripples_one = r_ripples_one;
        n_ripples_two = r_ripples_two;
        n_stall_one   = r_stall_one;
        n_stall_two   = r_stall_two;
        n_tick        = r_tick;
        n_status_one  = r_status_one;
        n_status_two  = r_status_two;
        n_done        = 1'b0;
        if (is_tick) begin
            n_tick = r_tick + TB'(1);
            if (n_tick == r_report_ticks) begin
                n_tick       = '0;
                n_status_one = classify(r_ripples_one, r_running_count, r_supply_on);
                n_status_two = classify(r_ripples_two, r_running_count, r_supply_on);
                n_done       = 1'b1;
            end
        end else begin
            n_ripples_one = fan_one_nx.ripples;
            n_ripples_two = fan_two_nx.ripples;
            n_stall_one   = fan_one_nx.stall;
            n_stall_two   = fan_two_nx.stall;
        end
    end

    assign ripples_one_ext = CW'(n_ripples_one);
    assign ripples_two_ext = CW'(n_ripples_two);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_one       <= frsm_pkg::RST_RIPPLE_LIMIT_ONE;
            r_limit_two       <= frsm_pkg::RST_RIPPLE_LIMIT_TWO;
            r_stall_limit     <= frsm_pkg::RST_STALL_LIMIT;
            r_running_count   <= frsm_pkg::RST_RUNNING_COUNT;
            r_supply_on_level <= frsm_pkg::RST_SUPPLY_ON_LEVEL;
            r_report_ticks    <= frsm_pkg::RST_REPORT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                frsm_pkg::CFG_RIPPLE_LIMIT_ONE: r_limit_one       <= i_cfg_data[LB-1:0];
                frsm_pkg::CFG_RIPPLE_LIMIT_TWO: r_limit_two       <= i_cfg_data[LB-1:0];
                frsm_pkg::CFG_STALL_LIMIT:      r_stall_limit     <= i_cfg_data[SB-1:0];
                frsm_pkg::CFG_RUNNING_COUNT:    r_running_count   <= i_cfg_data[RB-1:0];
                frsm_pkg::CFG_SUPPLY_ON_LEVEL:  r_supply_on_level <= i_cfg_data[LB-1:0];
                frsm_pkg::CFG_REPORT_TICKS:     r_report_ticks    <= i_cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    // fan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_one    <= '0;
            r_last_two    <= '0;
            r_ripples_one <= '0;
            r_ripples_two <= '0;
            r_stall_one   <= '0;
            r_stall_two   <= '0;
            r_tick        <= '0;
            r_supply_on   <= 1'b0;
            r_status_one  <= frsm_pkg::ST_NONE;
            r_status_two  <= frsm_pkg::ST_NONE;
        end else if (accept) begin
            r_ripples_one <= n_ripples_one;
            r_ripples_two <= n_ripples_two;
            r_stall_one   <= n_stall_one;
            r_stall_two   <= n_stall_two;
            r_tick        <= n_tick;
            r_status_one  <= n_status_one;
            r_status_two  <= n_status_two;
            if (!is_tick) begin
                r_last_one  <= i_req.fan_one_level;
                r_last_two  <= i_req.fan_two_level;
                r_supply_on <= (i_req.supply_level >= r_supply_on_level);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status_one  <= n_status_one;
            r_out_status_two  <= n_status_two;
            r_out_done        <= n_done;
            r_out_ripples_one <= ripples_one_ext[OB-1:0];
            r_out_ripples_two <= ripples_two_ext[OB-1:0];
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.fan_one_status  = r_out_status_one;
    assign o_rsp.fan_two_status  = r_out_status_two;
    assign o_rsp.report_done     = r_out_done;
    assign o_rsp.fan_one_ripples = r_out_ripples_one;
    assign o_rsp.fan_two_ripples = r_out_ripples_two;

endmodule

`default_nettype wire

// ===== sim/frsm_tb_pkg.sv =====
// Result record and scoreboard class for the fan ripple stall monitor bench.
`timescale 1ns / 1ps

package frsm_tb_pkg;

    typedef struct packed {
        frsm_pkg::t_fan_status            one_status;
        frsm_pkg::t_fan_status            two_status;
        logic                             report_done;
        logic [frsm_pkg::RIPPLE_BITS-1:0] one_ripples;
        logic [frsm_pkg::RIPPLE_BITS-1:0] two_ripples;
    } t_fan_report;

    class fan_scoreboard;
        logic [frsm_pkg::LEVEL_BITS-1:0]  limit_one;
        logic [frsm_pkg::LEVEL_BITS-1:0]  limit_two;
        logic [frsm_pkg::STALL_BITS-1:0]  stall_limit;
        logic [frsm_pkg::RUN_BITS-1:0]    run_threshold;
        logic [frsm_pkg::LEVEL_BITS-1:0]  supply_threshold;
        logic [frsm_pkg::TICK_BITS-1:0]   report_period;

        logic [frsm_pkg::LEVEL_BITS-1:0]  prev_one;
        logic [frsm_pkg::LEVEL_BITS-1:0]  prev_two;
        logic [frsm_pkg::RIPPLE_BITS-1:0] count_one;
        logic [frsm_pkg::RIPPLE_BITS-1:0] count_two;
        logic [frsm_pkg::STALL_BITS-1:0]  quiet_one;
        logic [frsm_pkg::STALL_BITS-1:0]  quiet_two;
        logic [frsm_pkg::TICK_BITS-1:0]   ticks;
        logic                             powered;
        frsm_pkg::t_fan_status            stat_one;
        frsm_pkg::t_fan_status            stat_two;

        t_fan_report                      report_q[$];
        int                               mismatches;

        function new();
            limit_one        = frsm_pkg::RST_RIPPLE_LIMIT_ONE;
            limit_two        = frsm_pkg::RST_RIPPLE_LIMIT_TWO;
            stall_limit      = frsm_pkg::RST_STALL_LIMIT;
            run_threshold    = frsm_pkg::RST_RUNNING_COUNT;
            supply_threshold = frsm_pkg::RST_SUPPLY_ON_LEVEL;
            report_period    = frsm_pkg::RST_REPORT_TICKS;
            prev_one   = '0;
            prev_two   = '0;
            count_one  = '0;
            count_two  = '0;
            quiet_one  = '0;
            quiet_two  = '0;
            ticks      = '0;
            powered    = 1'b0;
            stat_one   = frsm_pkg::ST_NONE;
            stat_two   = frsm_pkg::ST_NONE;
            mismatches = 0;
        endfunction

        function void write_reg(logic [frsm_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [frsm_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                frsm_pkg::CFG_RIPPLE_LIMIT_ONE:
                    limit_one        = data[frsm_pkg::LEVEL_BITS-1:0];
                frsm_pkg::CFG_RIPPLE_LIMIT_TWO:
                    limit_two        = data[frsm_pkg::LEVEL_BITS-1:0];
                frsm_pkg::CFG_STALL_LIMIT:
                    stall_limit      = data[frsm_pkg::STALL_BITS-1:0];
                frsm_pkg::CFG_RUNNING_COUNT:
                    run_threshold    = data[frsm_pkg::RUN_BITS-1:0];
                frsm_pkg::CFG_SUPPLY_ON_LEVEL:
                    supply_threshold = data[frsm_pkg::LEVEL_BITS-1:0];
                frsm_pkg::CFG_REPORT_TICKS:
                    report_period    = data[frsm_pkg::TICK_BITS-1:0];
                default: ;
            endcase
        endfunction

        // One fan: ripple detection, saturating counts, stall clear.
        function void track_fan(input logic [frsm_pkg::LEVEL_BITS-1:0] lvl,
                                input logic [frsm_pkg::LEVEL_BITS-1:0] lim,
                                inout logic [frsm_pkg::LEVEL_BITS-1:0] prev,
                                inout logic [frsm_pkg::RIPPLE_BITS-1:0] count,
                                inout logic [frsm_pkg::STALL_BITS-1:0] quiet);
            logic [frsm_pkg::LEVEL_BITS-1:0] step;
            step = (lvl > prev) ? lvl - prev : prev - lvl;
            if (lvl < lim && step > 1) begin
                if (count != '1) count = count + 1'b1;
                quiet = '0;
            end else if (quiet != frsm_pkg::STALL_MAX) begin
                quiet = quiet + 1'b1;
            end
            if (quiet == stall_limit) count = '0;
            prev = lvl;
        endfunction

        function frsm_pkg::t_fan_status grade(logic [frsm_pkg::RIPPLE_BITS-1:0] count);
            if (count > run_threshold) return frsm_pkg::ST_RUNNING;
            return powered ? frsm_pkg::ST_ERROR : frsm_pkg::ST_POWER_OFF;
        endfunction

        function void note_request(frsm_pkg::t_cmd cmd,
                                   logic [frsm_pkg::LEVEL_BITS-1:0] lvl_one,
                                   logic [frsm_pkg::LEVEL_BITS-1:0] lvl_two,
                                   logic [frsm_pkg::LEVEL_BITS-1:0] supply);
            t_fan_report r;
            r.report_done = 1'b0;
            if (cmd == frsm_pkg::CMD_SAMPLE) begin
                track_fan(lvl_one, limit_one, prev_one, count_one, quiet_one);
                track_fan(lvl_two, limit_two, prev_two, count_two, quiet_two);
                powered = (supply >= supply_threshold);
            end else begin
                ticks = ticks + 1'b1;
                if (ticks == report_period) begin
                    ticks         = '0;
                    stat_one      = grade(count_one);
                    stat_two      = grade(count_two);
                    r.report_done = 1'b1;
                end
            end
            r.one_status  = stat_one;
            r.two_status  = stat_two;
            r.one_ripples = count_one;
            r.two_ripples = count_two;
            report_q.push_back(r);
        endfunction

        function void check_result(t_fan_report got);
            t_fan_report want;
            bit          bad;
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result with no request pending: ",
                              "st1=%0d st2=%0d rep=%0b r1=%0d r2=%0d"},
                             got.one_status, got.two_status, got.report_done,
                             got.one_ripples, got.two_ripples);
                return;
            end
            want = report_q.pop_front();
            bad = (got.one_status  !== want.one_status)  ||
                  (got.two_status  !== want.two_status)  ||
                  (got.report_done !== want.report_done) ||
                  (got.one_ripples !== want.one_ripples) ||
                  (got.two_ripples !== want.two_ripples);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected st1=%0d st2=%0d rep=%0b r1=%0d r2=%0d, ",
                              "got st1=%0d st2=%0d rep=%0b r1=%0d r2=%0d"},
                             want.one_status, want.two_status, want.report_done,
                             want.one_ripples, want.two_ripples,
                             got.one_status, got.two_status, got.report_done,
                             got.one_ripples, got.two_ripples);
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction
    endclass

endpackage

// ===== sim/fan_ripple_stall_monitor_tb.sv =====
// Self-checking bench for the two-fan ripple stall monitor.
`timescale 1ns / 1ps

module fan_ripple_stall_monitor_tb;

    localparam int LB = frsm_pkg::LEVEL_BITS;
    localparam int IB = frsm_pkg::CFG_IDX_BITS;
    localparam int DB = frsm_pkg::CFG_DATA_BITS;

    // Cycles with no handshake on either channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Random requests per configuration segment (six segments)
    localparam int SEG_ITEMS      = 190;

    // Indexes that decode to no register; writes there must be dropped
    localparam logic [IB-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [IB-1:0] CFG_UNUSED_HI = 3'd7;

    // How the random part drives one fan's level
    typedef enum {
        FAN_RIPPLE,     // below the limit, jumping around: counts ripples
        FAN_QUIET,      // within 1 of the last level: advances the stall count
        FAN_NOISE       // full range of levels
    } t_fan_drive;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [IB-1:0]  i_cfg_idx;
    logic [DB-1:0]  i_cfg_data;

    frsm_req_if req_if ();
    frsm_rsp_if rsp_if ();

    fan_ripple_stall_monitor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    frsm_tb_pkg::fan_scoreboard sb = new();

    int src_idle_pct  = 26;
    int sink_idle_pct = 73;
    int stuck_cycles  = 0;

    // Levels last sent, so quiet drive can stay within one count
    logic [LB-1:0] last_one = '0;
    logic [LB-1:0] last_two = '0;

    frsm_tb_pkg::t_fan_report seen_result;

    always #5 i_clk = ~i_clk;

    // Receiver: drops ready at random according to the current regime
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    // Channel monitor: values read here are the ones sampled at this edge.
    // The result register lies between a request and its result, so a request
    // is always noted before its result shows up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                seen_result.one_status  = frsm_pkg::t_fan_status'(rsp_if.fan_one_status);
                seen_result.two_status  = frsm_pkg::t_fan_status'(rsp_if.fan_two_status);
                seen_result.report_done = rsp_if.report_done;
                seen_result.one_ripples = rsp_if.fan_one_ripples;
                seen_result.two_ripples = rsp_if.fan_two_ripples;
                sb.check_result(seen_result);
            end
            if (req_if.valid && req_if.ready)
                sb.note_request(frsm_pkg::t_cmd'(req_if.cmd), req_if.fan_one_level,
                                req_if.fan_two_level, req_if.supply_level);
        end
    end

    // Watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Offer one request and return at the edge that takes it. A random gap
    // (or, with hold set, a full drain of pending results) comes first.
    task automatic send_req(input frsm_pkg::t_cmd cmd, input logic [LB-1:0] lvl_one,
                            input logic [LB-1:0] lvl_two,
                            input logic [LB-1:0] supply, input bit hold);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < src_idle_pct) gap++;
        if (hold) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            wait_drained();
        end else if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.cmd           <= cmd;
        req_if.fan_one_level <= lvl_one;
        req_if.fan_two_level <= lvl_two;
        req_if.supply_level  <= supply;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Close a phase: stop requesting and let every result come back
    task automatic end_phase();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (2) @(posedge i_clk);
    endtask

    // Leading wait keeps the raise and the lower of the enable in separate steps
    task automatic write_reg(input logic [IB-1:0] idx, input logic [DB-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_settings(input int lim_one, input int lim_two, input int stall,
                                  input int run, input int supply, input int period);
        write_reg(frsm_pkg::CFG_RIPPLE_LIMIT_ONE, DB'(lim_one));
        write_reg(frsm_pkg::CFG_RIPPLE_LIMIT_TWO, DB'(lim_two));
        write_reg(frsm_pkg::CFG_STALL_LIMIT, DB'(stall));
        write_reg(frsm_pkg::CFG_RUNNING_COUNT, DB'(run));
        write_reg(frsm_pkg::CFG_SUPPLY_ON_LEVEL, DB'(supply));
        write_reg(frsm_pkg::CFG_REPORT_TICKS, DB'(period));
    endtask

    function automatic t_fan_drive pick_drive();
        int r;
        r = $urandom_range(9, 0);
        if (r < 5) return FAN_RIPPLE;
        if (r < 8) return FAN_QUIET;
        return FAN_NOISE;
    endfunction

    function automatic logic [LB-1:0] pick_level(t_fan_drive drive,
                                                 logic [LB-1:0] last,
                                                 logic [LB-1:0] lim);
        int v;
        case (drive)
            FAN_RIPPLE: begin
                if (lim == '0) return LB'($urandom_range(4095, 0));
                return LB'($urandom_range(int'(lim) - 1, 0));
            end
            FAN_QUIET: begin
                v = int'(last) + int'($urandom_range(2, 0)) - 1;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return LB'(v);
            end
            default: return LB'($urandom_range(4095, 0));
        endcase
    endfunction

    // Random requests: fan bursts of ripple, quiet or noise, ticks mixed in.
    // Halfway through, the sender holds off until every result is back.
    task automatic run_random(input int count);
        t_fan_drive    drive_one;
        t_fan_drive    drive_two;
        int            left_one;
        int            left_two;
        logic [LB-1:0] lvl_one;
        logic [LB-1:0] lvl_two;
        logic [LB-1:0] supply;
        drive_one = FAN_NOISE;
        drive_two = FAN_NOISE;
        left_one  = 0;
        left_two  = 0;
        for (int n = 0; n < count; n++) begin
            if (left_one == 0) begin
                drive_one = pick_drive();
                left_one  = $urandom_range(40, 1);
            end
            if (left_two == 0) begin
                drive_two = pick_drive();
                left_two  = $urandom_range(40, 1);
            end
            left_one--;
            left_two--;
            if ($urandom_range(99, 0) < 18) begin
                // sample fields ride along on a tick and must be ignored
                send_req(frsm_pkg::CMD_TICK, LB'($urandom_range(4095, 0)),
                         LB'($urandom_range(4095, 0)), LB'($urandom_range(4095, 0)),
                         n == count / 2);
            end else begin
                lvl_one = pick_level(drive_one, last_one, sb.limit_one);
                lvl_two = pick_level(drive_two, last_two, sb.limit_two);
                // supply around its threshold and at both rails
                case ($urandom_range(4, 0))
                    0:       supply = '0;
                    1:       supply = '1;
                    2:       supply = sb.supply_threshold;
                    3:       supply = sb.supply_threshold - 1'b1;
                    default: supply = LB'($urandom_range(4095, 0));
                endcase
                send_req(frsm_pkg::CMD_SAMPLE, lvl_one, lvl_two, supply, n == count / 2);
                last_one = lvl_one;
                last_two = lvl_two;
            end
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        req_if.valid         <= 1'b0;
        req_if.cmd           <= frsm_pkg::CMD_SAMPLE;
        req_if.fan_one_level <= '0;
        req_if.fan_two_level <= '0;
        req_if.supply_level  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values (limits 700/800, stall 10,
        // running 100, supply 253, report every 5 ticks).
        // First report with no ripples and power off.
        repeat (5) send_req(frsm_pkg::CMD_TICK, '1, '1, '1, 1'b0);
        // Ripple of exactly 2 on fan one, supply right at its threshold
        send_req(frsm_pkg::CMD_SAMPLE, 12'd2, 12'd0, 12'd253, 1'b0);
        // Step of 1 is no ripple; fan two one below its limit; supply one below
        send_req(frsm_pkg::CMD_SAMPLE, 12'd3, 12'd799, 12'd252, 1'b0);
        // Both levels at their limits: no ripple
        send_req(frsm_pkg::CMD_SAMPLE, 12'd700, 12'd800, 12'd4095, 1'b0);
        // Top of range, then a drop to zero that ripples both fans
        send_req(frsm_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 1'b0);
        send_req(frsm_pkg::CMD_SAMPLE, 12'd0, 12'd0, 12'd4095, 1'b0);
        send_req(frsm_pkg::CMD_SAMPLE, 12'd699, 12'd799, 12'd4095, 1'b0);
        // Report with power on and low counts: error on both fans
        repeat (5) send_req(frsm_pkg::CMD_TICK, '0, '0, '0, 1'b0);
        // Ten flat samples reach the stall limit and clear the counts
        repeat (10) send_req(frsm_pkg::CMD_SAMPLE, 12'd699, 12'd799, 12'd0, 1'b0);
        end_phase();

        // Extremes, low side: stall limit zero (a ripple clears its own count),
        // report every 16 ticks, dead-low fan one limit. Junk indexes first.
        write_reg(CFG_UNUSED_LO, DB'($urandom_range(65535, 0)));
        write_reg(CFG_UNUSED_HI, DB'($urandom_range(65535, 0)));
        apply_settings(0, 4095, 0, 0, 0, 0);
        run_random(SEG_ITEMS);
        end_phase();

        // Extremes, high side
        apply_settings(4095, 0, 15, 65535, 4095, 15);
        run_random(SEG_ITEMS);
        end_phase();

        // Sender mostly idle, receiver mostly ready
        src_idle_pct  = 73;
        sink_idle_pct = 26;
        repeat (2) begin
            apply_settings($urandom_range(4095, 0), $urandom_range(4095, 0),
                           $urandom_range(15, 1), $urandom_range(30, 0),
                           $urandom_range(4095, 0), $urandom_range(6, 1));
            run_random(SEG_ITEMS);
            end_phase();
        end

        // No idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (2) begin
            apply_settings($urandom_range(4095, 0), $urandom_range(4095, 0),
                           $urandom_range(15, 1), $urandom_range(30, 0),
                           $urandom_range(4095, 0), $urandom_range(6, 1));
            run_random(SEG_ITEMS);
            end_phase();
        end

        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
